// ===== hdl/fta_pkg.sv =====
// Package for the fixed-timestep accumulator: microcode types, the control
// store, register indexes, result kinds and range limits.
// No dependencies; used by fixed_timestep_accumulator.
package fta_pkg;

    // Register indexes on the configuration port
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_FIXED_MODE = 3'd0;
    localparam reg_idx_t REG_TIME_SCALE = 3'd1;
    localparam reg_idx_t REG_MAX_DELTA  = 3'd2;
    localparam reg_idx_t REG_FIXED_STEP = 3'd3;
    localparam reg_idx_t REG_MAX_STEPS  = 3'd4;

    // Result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FIXED    = 2'd0;
    localparam kind_t KIND_VARIABLE = 2'd1;
    localparam kind_t KIND_END      = 2'd2;

    // Limits and reset values
    localparam logic [23:0] STEP_MIN_US       = 24'd100;
    localparam logic [23:0] STEP_MAX_US       = 24'd10000000;
    localparam logic [5:0]  MAX_STEPS_LIMIT   = 6'd63;
    localparam logic [15:0] TIME_SCALE_RST    = 16'd256;
    localparam logic [23:0] MAX_DELTA_RST     = 24'd100000;
    localparam logic [23:0] FIXED_STEP_RST    = 24'd16667;
    localparam logic [5:0]  MAX_STEPS_RST     = 6'd5;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_MUL,
        OP_CLAMP,
        OP_EMIT_VAR,
        OP_ADD,
        OP_EMIT_FIXED,
        OP_SETTLE,
        OP_DIV_STEP,
        OP_EMIT_END
    } op_t;

    // Jump conditions; when true the word's operation is skipped
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_INPUT,
        C_FIXED_MODE,
        C_LOOP_DONE,
        C_DIV_DONE
    } cond_t;

    // Microcode addresses
    typedef logic [3:0] upc_t;
    localparam upc_t A_WAIT   = 4'd0;
    localparam upc_t A_MUL    = 4'd1;
    localparam upc_t A_CLAMP  = 4'd2;
    localparam upc_t A_MODE   = 4'd3;
    localparam upc_t A_ADD    = 4'd4;
    localparam upc_t A_LOOP   = 4'd5;
    localparam upc_t A_SETTLE = 4'd6;
    localparam upc_t A_DIV    = 4'd7;
    localparam upc_t A_END    = 4'd8;

    localparam int UCODE_DEPTH = 9;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  jump_to;   // taken when cond holds
        upc_t  seq_to;    // taken after the operation runs
    } ucode_t;

    // Control store
    localparam ucode_t UCODE [UCODE_DEPTH] = '{
        '{OP_ACCEPT,     C_NO_INPUT,   A_WAIT,   A_MUL},
        '{OP_MUL,        C_NEVER,      A_WAIT,   A_CLAMP},
        '{OP_CLAMP,      C_NEVER,      A_WAIT,   A_MODE},
        '{OP_EMIT_VAR,   C_FIXED_MODE, A_ADD,    A_WAIT},
        '{OP_ADD,        C_NEVER,      A_WAIT,   A_LOOP},
        '{OP_EMIT_FIXED, C_LOOP_DONE,  A_SETTLE, A_LOOP},
        '{OP_SETTLE,     C_NEVER,      A_WAIT,   A_DIV},
        '{OP_DIV_STEP,   C_DIV_DONE,   A_END,    A_DIV},
        '{OP_EMIT_END,   C_NEVER,      A_WAIT,   A_WAIT}
    };

endpackage

// ===== hdl/fixed_timestep_accumulator.sv =====
// Fixed-timestep accumulator top level: microcoded sequencer and datapath.
// Depends on fta_pkg (control store, codes, limits).
//
// One frame delta per request. In variable mode a request yields one variable
// step. In fixed mode a request yields N fixed steps, N being at most
// max_steps_per_frame: the step loop emits one step per cycle while the output
// register is free, then the restoring divider that forms the alpha produces
// one quotient bit per cycle. Each result waits in a single output register;
// the sequencer stalls on a result while that register is still held. A new
// request is taken only when the program is back at its wait word.
module fixed_timestep_accumulator #(
    parameter int ALPHA_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // frame input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] frame_delta_us
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] step_duration_us, [29:24] step_index,
                                   // [45:30] interp_alpha, [46] backlog_dropped,
                                   // [47] zero
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last_result
);

    localparam int CNT_W = $clog2(ALPHA_BITS + 1);
    localparam int QW    = (ALPHA_BITS > 16) ? ALPHA_BITS : 16;

    // Sequencer and configuration state
    fta_pkg::upc_t   pc_reg, pc_next;
    logic            mode_reg, mode_next;
    logic [15:0]     scale_reg, scale_next;
    logic [23:0]     maxd_reg, maxd_next;
    logic [23:0]     step_reg, step_next;
    logic [5:0]      cap_reg, cap_next;
    logic [24:0]     tacc_reg, tacc_next;
    logic [15:0]     ahold_reg, ahold_next;
    logic            ovalid_reg, ovalid_next;

    // Datapath
    logic [23:0]     delta_reg, delta_next;
    logic [39:0]     prod_reg, prod_next;
    logic [23:0]     scaled_reg, scaled_next;
    logic [24:0]     acc_reg, acc_next;
    logic [5:0]      steps_reg, steps_next;
    logic            drop_reg, drop_next;
    logic [24:0]     rem_reg, rem_next;
    logic [ALPHA_BITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Output payload
    fta_pkg::kind_t  okind_reg, okind_next;
    logic [23:0]     odur_reg, odur_next;
    logic [5:0]      oidx_reg, oidx_next;
    logic [15:0]     oalpha_reg, oalpha_next;
    logic            odrop_reg, odrop_next;
    logic            olast_reg, olast_next;

    fta_pkg::ucode_t uword;
    logic            cond_hit, is_emit, out_free, stall, exec;
    logic [24:0]     rem_sh;
    logic            rem_ge;
    logic [QW-1:0]   q_wide;
    logic [15:0]     alpha_sat;
    logic [24:0]     acc_final;
    logic [23:0]     cfg_step;
    logic [5:0]      cfg_cap;

    // Current control word and its jump condition
    always_comb
    begin
        uword = fta_pkg::UCODE[pc_reg];
        case (uword.cond)
            fta_pkg::C_NEVER:      cond_hit = 1'b0;
            fta_pkg::C_NO_INPUT:   cond_hit = !s_tvalid;
            fta_pkg::C_FIXED_MODE: cond_hit = mode_reg;
            fta_pkg::C_LOOP_DONE:  cond_hit = (acc_reg < {1'b0, step_reg}) ||
                                              (steps_reg == cap_reg);
            fta_pkg::C_DIV_DONE:   cond_hit = (cnt_reg == CNT_W'(ALPHA_BITS));
            default:               cond_hit = 1'b0;
        endcase
        is_emit  = (uword.op == fta_pkg::OP_EMIT_VAR) ||
                   (uword.op == fta_pkg::OP_EMIT_FIXED) ||
                   (uword.op == fta_pkg::OP_EMIT_END);
        out_free = !ovalid_reg || m_tready;
        stall    = !cond_hit && is_emit && !out_free;
        exec     = !cond_hit && !stall;
    end

    assign s_tready = (uword.op == fta_pkg::OP_ACCEPT);

    // Divider step, alpha saturation, cap handling
    always_comb
    begin
        rem_sh    = {rem_reg[23:0], 1'b0};
        rem_ge    = (rem_sh >= {1'b0, step_reg});
        q_wide    = QW'(q_reg);
        alpha_sat = (q_wide > QW'(17'h0FFFF)) ? 16'hFFFF : q_wide[15:0];
        acc_final = (steps_reg == cap_reg) ? 25'd0 : acc_reg;
    end

    // Clamped configuration values
    always_comb
    begin
        if (cfg_wdata < fta_pkg::STEP_MIN_US)
            cfg_step = fta_pkg::STEP_MIN_US;
        else if (cfg_wdata > fta_pkg::STEP_MAX_US)
            cfg_step = fta_pkg::STEP_MAX_US;
        else
            cfg_step = cfg_wdata;
        if (cfg_wdata[5:0] == 6'd0)
            cfg_cap = 6'd1;
        else if (cfg_wdata[5:0] > fta_pkg::MAX_STEPS_LIMIT)
            cfg_cap = fta_pkg::MAX_STEPS_LIMIT;
        else
            cfg_cap = cfg_wdata[5:0];
    end

    // Next-state logic for sequencer, datapath and output register
    always_comb
    begin
        pc_next     = cond_hit ? uword.jump_to : (stall ? pc_reg : uword.seq_to);
        mode_next   = mode_reg;
        scale_next  = scale_reg;
        maxd_next   = maxd_reg;
        step_next   = step_reg;
        cap_next    = cap_reg;
        tacc_next   = tacc_reg;
        ahold_next  = ahold_reg;
        ovalid_next = ovalid_reg && !m_tready;

        delta_next  = delta_reg;
        prod_next   = prod_reg;
        scaled_next = scaled_reg;
        acc_next    = acc_reg;
        steps_next  = steps_reg;
        drop_next   = drop_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;

        okind_next  = okind_reg;
        odur_next   = odur_reg;
        oidx_next   = oidx_reg;
        oalpha_next = oalpha_reg;
        odrop_next  = odrop_reg;
        olast_next  = olast_reg;

        // configuration writes
        if (cfg_wen)
        begin
            case (cfg_index)
                fta_pkg::REG_FIXED_MODE: mode_next  = cfg_wdata[0];
                fta_pkg::REG_TIME_SCALE: scale_next = cfg_wdata[15:0];
                fta_pkg::REG_MAX_DELTA:  maxd_next  = cfg_wdata;
                fta_pkg::REG_FIXED_STEP:
                begin
                    step_next = cfg_step;
                    tacc_next = {1'b0, cfg_step};
                end
                fta_pkg::REG_MAX_STEPS:  cap_next   = cfg_cap;
                default: ;
            endcase
        end

        // datapath operation of the current word
        if (exec)
        begin
            case (uword.op)
                fta_pkg::OP_ACCEPT:
                    delta_next = s_tdata;
                fta_pkg::OP_MUL:
                    prod_next = 40'(delta_reg) * 40'(scale_reg);
                fta_pkg::OP_CLAMP:
                begin
                    if (prod_reg[39:8] > {8'd0, maxd_reg})
                        scaled_next = maxd_reg;
                    else
                        scaled_next = prod_reg[31:8];
                end
                fta_pkg::OP_EMIT_VAR:
                begin
                    ovalid_next = 1'b1;
                    okind_next  = fta_pkg::KIND_VARIABLE;
                    odur_next   = scaled_reg;
                    oidx_next   = 6'd0;
                    oalpha_next = ahold_reg;
                    odrop_next  = 1'b0;
                    olast_next  = 1'b1;
                end
                fta_pkg::OP_ADD:
                begin
                    acc_next   = tacc_reg + {1'b0, scaled_reg};
                    steps_next = 6'd0;
                end
                fta_pkg::OP_EMIT_FIXED:
                begin
                    ovalid_next = 1'b1;
                    okind_next  = fta_pkg::KIND_FIXED;
                    odur_next   = step_reg;
                    oidx_next   = steps_reg;
                    oalpha_next = 16'd0;
                    odrop_next  = 1'b0;
                    olast_next  = 1'b0;
                    acc_next    = acc_reg - {1'b0, step_reg};
                    steps_next  = steps_reg + 6'd1;
                end
                fta_pkg::OP_SETTLE:
                begin
                    drop_next = (steps_reg == cap_reg);
                    acc_next  = acc_final;
                    tacc_next = acc_final;
                    rem_next  = acc_final;
                    q_next    = '0;
                    cnt_next  = '0;
                end
                fta_pkg::OP_DIV_STEP:
                begin
                    rem_next = rem_ge ? (rem_sh - {1'b0, step_reg}) : rem_sh;
                    q_next   = {q_reg[ALPHA_BITS-2:0], rem_ge};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                fta_pkg::OP_EMIT_END:
                begin
                    ahold_next  = alpha_sat;
                    ovalid_next = 1'b1;
                    okind_next  = fta_pkg::KIND_END;
                    odur_next   = 24'd0;
                    oidx_next   = steps_reg;
                    oalpha_next = alpha_sat;
                    odrop_next  = drop_reg;
                    olast_next  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Control, configuration and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= fta_pkg::A_WAIT;
            mode_reg   <= 1'b0;
            scale_reg  <= fta_pkg::TIME_SCALE_RST;
            maxd_reg   <= fta_pkg::MAX_DELTA_RST;
            step_reg   <= fta_pkg::FIXED_STEP_RST;
            cap_reg    <= fta_pkg::MAX_STEPS_RST;
            tacc_reg   <= {1'b0, fta_pkg::FIXED_STEP_RST};
            ahold_reg  <= 16'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            mode_reg   <= mode_next;
            scale_reg  <= scale_next;
            maxd_reg   <= maxd_next;
            step_reg   <= step_next;
            cap_reg    <= cap_next;
            tacc_reg   <= tacc_next;
            ahold_reg  <= ahold_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        delta_reg  <= delta_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        acc_reg    <= acc_next;
        steps_reg  <= steps_next;
        drop_reg   <= drop_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        okind_reg  <= okind_next;
        odur_reg   <= odur_next;
        oidx_reg   <= oidx_next;
        oalpha_reg <= oalpha_next;
        odrop_reg  <= odrop_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, odrop_reg, oalpha_reg, oidx_reg, odur_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    // Stored accumulator never exceeds one fixed step
    a_tacc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tacc_reg <= {1'b0, step_reg})
        else $error("time accumulator above fixed step");

    // Step loop never runs past the cap
    a_steps_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == fta_pkg::A_LOOP) |-> (steps_reg <= cap_reg))
        else $error("step count beyond cap");

    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == fta_pkg::A_DIV) |-> (rem_reg < {1'b0, step_reg}))
        else $error("divider remainder out of range");

    // Frame end result lands in the output register as the last of its frame
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == fta_pkg::A_END && exec) |=>
            (m_tvalid && m_tlast && m_tuser == fta_pkg::KIND_END))
        else $error("frame end result not presented");

    // Step cap register is never zero
    a_cap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg != 6'd0)
        else $error("step cap is zero");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for fixed_timestep_accumulator: streams frame deltas in and checks every step and
// frame-end result against an in-bench model of scaling, accumulation, step cap and alpha.
// Depends on fta_pkg and hdl/fixed_timestep_accumulator.sv.
module tb_top;

    localparam int ALPHA_BITS  = 16;
    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 18;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE_GAP  = 4;
    localparam int TAIL_CYCLES = 40;
    // Indexes above REG_MAX_STEPS are unmapped
    localparam fta_pkg::reg_idx_t REG_SPARE_FIRST = 3'd5;
    localparam int                N_SPARE         = 3;

    typedef struct packed {
        fta_pkg::kind_t kind;
        logic [23:0]    dur;
        logic [5:0]     idx;
        logic [15:0]    alpha;
        logic           drop;
        logic           last;
    } step_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [23:0] frame_delta_us
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // [23:0] dur, [29:24] index, [45:30] alpha, [46] dropped
    logic [1:0]  m_tuser;          // [1:0] result_kind
    logic        m_tlast;

    // Register and state copies of the block
    logic        cur_fixed_mode = 1'b0;
    logic [15:0] cur_scale      = fta_pkg::TIME_SCALE_RST;
    logic [23:0] cur_max_delta  = fta_pkg::MAX_DELTA_RST;
    logic [23:0] cur_step       = fta_pkg::FIXED_STEP_RST;
    logic [5:0]  cur_max_steps  = fta_pkg::MAX_STEPS_RST;
    logic [24:0] acc_mirror     = {1'b0, fta_pkg::FIXED_STEP_RST};
    logic [15:0] alpha_mirror   = '0;

    logic [23:0]  frame_q[$];      // deltas waiting to be sent
    step_result_t step_q[$];       // results still owed by the block

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          src_gap      = 0;
    int          sink_gap     = 0;
    int          hold_seq     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int unsigned cycle_cnt    = 0;

    int frames_done = 0;
    int results_cnt = 0;
    int fixed_cnt   = 0;
    int var_cnt     = 0;
    int end_cnt     = 0;
    int drop_cnt    = 0;
    int deepest_idx = 0;
    int bad_cnt     = 0;

    fixed_timestep_accumulator #(
        .ALPHA_BITS (ALPHA_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, step_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Scale, clamp, accumulate and split one frame into expected results
    function automatic void predict_frame(input logic [23:0] delta);
        logic [39:0] prod;
        logic [31:0] scaled_w;
        logic [23:0] scaled;
        logic [24:0] acc;
        logic [5:0]  n_steps;
        logic        dropped;
        logic [40:0] num;
        logic [40:0] quot;
        logic [15:0] alpha;
        prod     = 40'(delta) * 40'(cur_scale);
        scaled_w = prod[39:8];
        scaled   = (scaled_w > {8'd0, cur_max_delta}) ? cur_max_delta : scaled_w[23:0];
        if (!cur_fixed_mode)
        begin
            step_q.push_back(step_result_t'{fta_pkg::KIND_VARIABLE, scaled, 6'd0,
                                            alpha_mirror, 1'b0, 1'b1});
            return;
        end
        acc     = acc_mirror + {1'b0, scaled};
        n_steps = '0;
        dropped = 1'b0;
        while (acc >= {1'b0, cur_step} && n_steps < cur_max_steps)
        begin
            step_q.push_back(step_result_t'{fta_pkg::KIND_FIXED, cur_step, n_steps, 16'd0,
                                            1'b0, 1'b0});
            acc     = acc - {1'b0, cur_step};
            n_steps = n_steps + 6'd1;
        end
        // cap hit drops the backlog, even if the last step used it up exactly
        if (n_steps == cur_max_steps)
        begin
            acc     = '0;
            dropped = 1'b1;
        end
        num   = {16'd0, acc} << ALPHA_BITS;
        quot  = num / {17'd0, cur_step};
        alpha = (quot > 41'h0FFFF) ? 16'hFFFF : quot[15:0];
        acc_mirror   = acc;
        alpha_mirror = alpha;
        step_q.push_back(step_result_t'{fta_pkg::KIND_END, 24'd0, n_steps, alpha, dropped,
                                        1'b1});
    endfunction

    // Request driver: hold until taken, random gaps between requests
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_frame(s_tdata);
                frames_done++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (frame_q.size() > 0)
                begin
                    s_tdata  <= frame_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (src_idle_en && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 5);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: long hold on request, else random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : monitor
        step_result_t got;
        step_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = m_tuser;
            got.dur   = m_tdata[23:0];
            got.idx   = m_tdata[29:24];
            got.alpha = m_tdata[45:30];
            got.drop  = m_tdata[46];
            got.last  = m_tlast;
            results_cnt++;
            if (step_q.size() == 0)
            begin
                bad_cnt++;
                if (bad_cnt <= MAX_REPORTS)
                    $display({"unexpected result: kind=%0d dur=%0d idx=%0d alpha=%0d",
                              " drop=%0d last=%0d"},
                             got.kind, got.dur, got.idx, got.alpha, got.drop, got.last);
            end
            else
            begin
                want = step_q.pop_front();
                if (got !== want || m_tdata[47] !== 1'b0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch at result %0d", results_cnt);
                        $display({"  exp kind=%0d dur=%0d idx=%0d alpha=%0d drop=%0d",
                                  " last=%0d pad=0"},
                                 want.kind, want.dur, want.idx, want.alpha, want.drop,
                                 want.last);
                        $display({"  got kind=%0d dur=%0d idx=%0d alpha=%0d drop=%0d",
                                  " last=%0d pad=%0d"},
                                 got.kind, got.dur, got.idx, got.alpha, got.drop, got.last,
                                 m_tdata[47]);
                    end
                end
                case (want.kind)
                    fta_pkg::KIND_FIXED:    fixed_cnt++;
                    fta_pkg::KIND_VARIABLE: var_cnt++;
                    default:
                    begin
                        end_cnt++;
                        if (want.drop)
                            drop_cnt++;
                        if (int'(want.idx) > deepest_idx)
                            deepest_idx = int'(want.idx);
                    end
                endcase
            end
        end
    end

    // Register write while idle; mirrors the masking and clamping of the block
    task automatic write_reg(input fta_pkg::reg_idx_t idx, input logic [23:0] val);
        logic [23:0] step_v;
        logic [5:0]  cap_v;
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            fta_pkg::REG_FIXED_MODE: cur_fixed_mode = val[0];
            fta_pkg::REG_TIME_SCALE: cur_scale = val[15:0];
            fta_pkg::REG_MAX_DELTA:  cur_max_delta = val;
            fta_pkg::REG_FIXED_STEP:
            begin
                step_v = val;
                if (step_v < fta_pkg::STEP_MIN_US)
                    step_v = fta_pkg::STEP_MIN_US;
                if (step_v > fta_pkg::STEP_MAX_US)
                    step_v = fta_pkg::STEP_MAX_US;
                cur_step   = step_v;
                acc_mirror = {1'b0, step_v};
            end
            fta_pkg::REG_MAX_STEPS:
            begin
                cap_v = val[5:0];
                if (cap_v == 6'd0)
                    cap_v = 6'd1;
                if (cap_v > fta_pkg::MAX_STEPS_LIMIT)
                    cap_v = fta_pkg::MAX_STEPS_LIMIT;
                cur_max_steps = cap_v;
            end
            default: ;  // unmapped index
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Sender pauses until every owed result has come and the block is back at rest
    task automatic drain();
        do
            @(negedge clk);
        while (frame_q.size() != 0 || s_tvalid || step_q.size() != 0);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [23:0] val;
        logic [23:0] delta;
        int unsigned bound;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unmapped indexes must leave the reset settings alone
        for (int k = 0; k < N_SPARE; k++)
            write_reg(3'(REG_SPARE_FIRST + 3'(k)), 24'($urandom));

        // Variable mode at reset settings: zero, full scale, exact clamp, typical
        frame_q.push_back(24'd0);
        frame_q.push_back(24'hFFFFFF);
        frame_q.push_back(24'd100000);
        frame_q.push_back(24'd12345);
        drain();

        // Fixed mode: one step from the reset backlog, cap hits, a fraction left over
        write_reg(fta_pkg::REG_FIXED_MODE, 24'd3);
        frame_q.push_back(24'd0);
        frame_q.push_back(24'd100000);
        frame_q.push_back(24'hFFFFFF);
        frame_q.push_back(24'd16666);
        drain();

        // Variable step with zero scale carries the held alpha
        write_reg(fta_pkg::REG_FIXED_MODE, 24'd2);
        write_reg(fta_pkg::REG_TIME_SCALE, 24'd0);
        frame_q.push_back(24'hFFFFFF);
        drain();

        // Back to fixed: accumulator survived the variable frame
        write_reg(fta_pkg::REG_FIXED_MODE, 24'd1);
        frame_q.push_back(24'h5A5A5A);
        drain();

        // Step below minimum, zero clamp: one step out of the backlog alone
        write_reg(fta_pkg::REG_FIXED_STEP, 24'd50);
        write_reg(fta_pkg::REG_TIME_SCALE, 24'hFFFFFF);
        write_reg(fta_pkg::REG_MAX_DELTA, 24'd0);
        frame_q.push_back(24'hFFFFFF);
        drain();

        // Step above maximum, cap of zero taken as one, widest clamp
        write_reg(fta_pkg::REG_FIXED_STEP, 24'hFFFFFF);
        write_reg(fta_pkg::REG_MAX_STEPS, 24'd0);
        write_reg(fta_pkg::REG_MAX_DELTA, 24'hFFFFFF);
        frame_q.push_back(24'hFFFFFF);
        frame_q.push_back(24'd0);
        drain();

        // Shortest step, largest cap: the longest burst of results
        write_reg(fta_pkg::REG_FIXED_STEP, 24'd100);
        write_reg(fta_pkg::REG_MAX_STEPS, 24'hFFFF7F);
        write_reg(fta_pkg::REG_TIME_SCALE, 24'd256);
        frame_q.push_back(24'hFFFFFF);
        drain();

        // Cap reached with the backlog used up exactly, then a remainder
        write_reg(fta_pkg::REG_FIXED_STEP, 24'd1000);
        write_reg(fta_pkg::REG_MAX_STEPS, 24'd2);
        frame_q.push_back(24'd1000);
        frame_q.push_back(24'd999);
        frame_q.push_back(24'd1500);
        drain();

        // Random phases: fresh settings each phase, then mostly step-sized deltas
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            src_idle_en  = (p != RAND_PHASES - 1) && (p != 3);
            sink_idle_en = (p != RAND_PHASES - 1);

            val = 24'($urandom);
            val[0] = (p % 4 != 2);
            write_reg(fta_pkg::REG_FIXED_MODE, val);

            val = 24'($urandom);
            case ($urandom_range(0, 3))
                0: val[15:0] = 16'd256;
                1: val[15:0] = 16'($urandom_range(0, 1024));
                2: val[15:0] = 16'($urandom);
                default: val[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0080;
            endcase
            write_reg(fta_pkg::REG_TIME_SCALE, val);

            case ($urandom_range(0, 2))
                0: val = 24'($urandom);
                1: val = 24'($urandom_range(0, 200000));
                default: val = 24'hFFFFFF;
            endcase
            write_reg(fta_pkg::REG_MAX_DELTA, val);

            if ($urandom_range(0, 3) == 0)
                val = 24'($urandom);
            else
                val = 24'($urandom_range(0, 40000));
            write_reg(fta_pkg::REG_FIXED_STEP, val);

            write_reg(fta_pkg::REG_MAX_STEPS, 24'($urandom));

            // Receiver stalls for a long stretch while requests keep coming
            if (p == 3)
                hold_seq++;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    7, 8: delta = 24'($urandom);
                    9:    delta = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
                    default:
                    begin
                        bound = cur_step * $urandom_range(1, 4);
                        if (bound > 32'hFFFFFF)
                            bound = 32'hFFFFFF;
                        delta = 24'($urandom_range(0, bound));
                    end
                endcase
                frame_q.push_back(delta);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d frames sent, %0d results checked: %0d fixed, %0d variable, %0d frame ends",
                 frames_done, results_cnt, fixed_cnt, var_cnt, end_cnt);
        $display("step cap hit on %0d frames, deepest step count %0d, %0d bad results",
                 drop_cnt, deepest_idx, bad_cnt);
        if (bad_cnt == 0 && step_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fta_pkg.sv
hdl/fixed_timestep_accumulator.sv
verif/tb_top.sv
